>>> rtl/core/arcade_board_memory_map_core_macros.svh
// Assertion macros used by the bus decoder checker.
`ifndef ARCADE_BOARD_MEMORY_MAP_CORE_MACROS_SVH
`define ARCADE_BOARD_MEMORY_MAP_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ABMM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("bus decoder check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ABMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("bus decoder check failed");

`endif

>>> rtl/core/abmm_pkg.sv
// Types, constants and address map of the arcade board bus decoder.
`timescale 1ns / 1ps
package abmm_pkg;

  localparam int ROM_AW   = 15;
  localparam int VRAM_AW  = 10;
  localparam int SPR_AW   = 8;
  localparam int WRAM_AW  = 12;
  localparam int ROM_DEPTH  = 1 << ROM_AW;
  localparam int VRAM_DEPTH = 1 << VRAM_AW;
  localparam int SPR_DEPTH  = 1 << SPR_AW;
  localparam int WRAM_DEPTH = 1 << WRAM_AW;

  // Fixed bus addresses
  localparam logic [15:0] ADR_LATCH = 16'h9800;
  localparam logic [15:0] ADR_SND1  = 16'h9801;
  localparam logic [15:0] ADR_SND2  = 16'h9802;
  localparam logic [15:0] ADR_PROT  = 16'h9803;
  localparam logic [15:0] ADR_P0    = 16'hA000;
  localparam logic [15:0] ADR_P1    = 16'hA001;
  localparam logic [15:0] ADR_DIP1  = 16'hA002;
  localparam logic [15:0] ADR_DIP2  = 16'hA003;

  // Region prefixes
  localparam logic [3:0] PFX_VRAM  = 4'h8;
  localparam logic [7:0] PFX_SPR   = 8'h90;
  localparam logic [3:0] PFX_WRAM  = 4'hE;
  localparam logic [4:0] PFX_SCRX  = 5'b11110;
  localparam logic [4:0] PFX_SCRY  = 5'b11111;

  localparam logic [1:0] VSEL_BGC = 2'd0;
  localparam logic [1:0] VSEL_BGV = 2'd1;
  localparam logic [1:0] VSEL_FGC = 2'd2;
  localparam logic [1:0] VSEL_FGV = 2'd3;

  localparam logic [7:0] BYTE_FF = 8'hFF;

  // Configuration register indexes
  localparam logic CFG_DIP1 = 1'b0;
  localparam logic CFG_DIP2 = 1'b1;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    SRC_FF,
    SRC_ROM,
    SRC_BGC,
    SRC_BGV,
    SRC_FGC,
    SRC_FGV,
    SRC_SPR,
    SRC_WRAM,
    SRC_P0,
    SRC_P1,
    SRC_DIP1,
    SRC_DIP2
  } src_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_LATCH,
    WR_SND1,
    WR_SND2,
    WR_SCRX,
    WR_SCRY
  } wr_t;

  typedef struct packed {
    logic bgc;
    logic bgv;
    logic fgc;
    logic fgv;
    logic spr;
    logic wram;
  } ram_we_t;

  typedef struct packed {
    src_t              src;
    wr_t               wr;
    ram_we_t           ram_we;
    logic              rom_we;
    logic [ROM_AW-1:0] rom_addr;
  } dec_t;

  typedef struct packed {
    logic [7:0] rom;
    logic [7:0] bgc;
    logic [7:0] bgv;
    logic [7:0] fgc;
    logic [7:0] fgv;
    logic [7:0] spr;
    logic [7:0] wram;
  } rdq_t;

endpackage

>>> rtl/core/abmm_decode.sv
// Address decoder: turns a bus transaction into read source, write target and enables.
`timescale 1ns / 1ps
module abmm_decode
  import abmm_pkg::*;
(
  input  logic [1:0]  command,
  input  logic [15:0] address,
  input  logic [15:0] protection_pointer,
  output dec_t        dec
);

  logic       is_rom;
  logic       is_vram;
  logic       is_spr;
  logic       is_wram;
  logic [1:0] vsel;

  assign is_rom  = ~address[15];
  assign is_vram = (address[15:12] == PFX_VRAM);
  assign is_spr  = (address[15:8] == PFX_SPR);
  assign is_wram = (address[15:12] == PFX_WRAM);
  assign vsel    = address[11:10];

  always_comb begin
    dec          = '0;
    dec.src      = SRC_FF;
    dec.wr       = WR_NONE;
    dec.rom_addr = address[ROM_AW-1:0];
    case (cmd_t'(command))
      CMD_READ: begin
        if (is_rom) begin
          dec.src = SRC_ROM;
        end else if (is_vram) begin
          case (vsel)
            VSEL_BGC: dec.src = SRC_BGC;
            VSEL_BGV: dec.src = SRC_BGV;
            VSEL_FGC: dec.src = SRC_FGC;
            VSEL_FGV: dec.src = SRC_FGV;
            default:  dec.src = SRC_FF;
          endcase
        end else if (is_spr) begin
          dec.src = SRC_SPR;
        end else if (is_wram) begin
          dec.src = SRC_WRAM;
        end else if (address == ADR_PROT) begin
          // Protection port reads ROM through the CPU pointer
          dec.rom_addr = protection_pointer[ROM_AW-1:0];
          if (!protection_pointer[15]) begin
            dec.src = SRC_ROM;
          end
        end else if (address == ADR_P0) begin
          dec.src = SRC_P0;
        end else if (address == ADR_P1) begin
          dec.src = SRC_P1;
        end else if (address == ADR_DIP1) begin
          dec.src = SRC_DIP1;
        end else if (address == ADR_DIP2) begin
          dec.src = SRC_DIP2;
        end
      end
      CMD_WRITE: begin
        if (is_vram) begin
          case (vsel)
            VSEL_BGC: dec.ram_we.bgc = 1'b1;
            VSEL_BGV: dec.ram_we.bgv = 1'b1;
            VSEL_FGC: dec.ram_we.fgc = 1'b1;
            VSEL_FGV: dec.ram_we.fgv = 1'b1;
            default:  dec.ram_we     = '0;
          endcase
        end else if (is_spr) begin
          dec.ram_we.spr = 1'b1;
        end else if (is_wram) begin
          dec.ram_we.wram = 1'b1;
        end else if (address == ADR_LATCH) begin
          dec.wr = WR_LATCH;
        end else if (address == ADR_SND1) begin
          dec.wr = WR_SND1;
        end else if (address == ADR_SND2) begin
          dec.wr = WR_SND2;
        end else if (address[15:11] == PFX_SCRX) begin
          dec.wr = WR_SCRX;
        end else if (address[15:11] == PFX_SCRY) begin
          dec.wr = WR_SCRY;
        end
      end
      CMD_LOAD: begin
        dec.rom_we = is_rom;
      end
      default: begin
        dec.src = SRC_FF;
      end
    endcase
  end

endmodule

>>> rtl/core/abmm_mem.sv
// Program ROM, video, sprite and work RAMs with the post-reset clearing sweep.
`timescale 1ns / 1ps
module abmm_mem
  import abmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  dec_t        dec,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output rdq_t        q,
  output logic        busy
);

  logic               clr_active_r;
  logic [WRAM_AW-1:0] clr_cnt_r;

  logic [7:0] rom_mem  [ROM_DEPTH];
  logic [7:0] bgc_mem  [VRAM_DEPTH];
  logic [7:0] bgv_mem  [VRAM_DEPTH];
  logic [7:0] fgc_mem  [VRAM_DEPTH];
  logic [7:0] fgv_mem  [VRAM_DEPTH];
  logic [7:0] spr_mem  [SPR_DEPTH];
  logic [7:0] wram_mem [WRAM_DEPTH];

  logic [7:0] rom_q_r, bgc_q_r, bgv_q_r, fgc_q_r, fgv_q_r, spr_q_r, wram_q_r;

  logic [VRAM_AW-1:0] vram_waddr;
  logic [SPR_AW-1:0]  spr_waddr;
  logic [WRAM_AW-1:0] wram_waddr;
  logic [7:0]         ram_wdata;
  ram_we_t            ram_we;

  // Sweep every RAM from zero to the top of work RAM after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (&clr_cnt_r) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign busy = clr_active_r;

  always_comb begin
    if (clr_active_r) begin
      vram_waddr = clr_cnt_r[VRAM_AW-1:0];
      spr_waddr  = clr_cnt_r[SPR_AW-1:0];
      wram_waddr = clr_cnt_r;
      ram_wdata  = '0;
      ram_we     = '1;
    end else begin
      vram_waddr = address[VRAM_AW-1:0];
      spr_waddr  = address[SPR_AW-1:0];
      wram_waddr = address[WRAM_AW-1:0];
      ram_wdata  = write_data;
      ram_we     = accept ? dec.ram_we : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dec.rom_we) begin
      rom_mem[dec.rom_addr] <= write_data;
    end
    rom_q_r <= rom_mem[dec.rom_addr];
  end

  always_ff @(posedge clk) begin
    if (ram_we.bgc) begin
      bgc_mem[vram_waddr] <= ram_wdata;
    end
    bgc_q_r <= bgc_mem[address[VRAM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ram_we.bgv) begin
      bgv_mem[vram_waddr] <= ram_wdata;
    end
    bgv_q_r <= bgv_mem[address[VRAM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ram_we.fgc) begin
      fgc_mem[vram_waddr] <= ram_wdata;
    end
    fgc_q_r <= fgc_mem[address[VRAM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ram_we.fgv) begin
      fgv_mem[vram_waddr] <= ram_wdata;
    end
    fgv_q_r <= fgv_mem[address[VRAM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ram_we.spr) begin
      spr_mem[spr_waddr] <= ram_wdata;
    end
    spr_q_r <= spr_mem[address[SPR_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ram_we.wram) begin
      wram_mem[wram_waddr] <= ram_wdata;
    end
    wram_q_r <= wram_mem[address[WRAM_AW-1:0]];
  end

  assign q = '{rom: rom_q_r, bgc: bgc_q_r, bgv: bgv_q_r, fgc: fgc_q_r,
               fgv: fgv_q_r, spr: spr_q_r, wram: wram_q_r};

endmodule

>>> rtl/core/abmm_result.sv
// Access stage register, read data select, board latches and result register.
`timescale 1ns / 1ps
module abmm_result
  import abmm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  src_t       src,
  input  wr_t        wr,
  input  logic [7:0] write_data,
  input  logic [7:0] player_port_0,
  input  logic [7:0] player_port_1,
  input  logic [7:0] dip1,
  input  logic [7:0] dip2,
  input  rdq_t       q,
  output logic       valid,
  output logic [7:0] read_data,
  output logic       sound_strobe_1,
  output logic       sound_strobe_2,
  output logic [7:0] sound_byte,
  output logic       flip_screen,
  output logic [2:0] priority_select,
  output logic [7:0] scroll_x,
  output logic [7:0] scroll_y
);

  logic       s1_valid_r;
  src_t       s1_src_r;
  wr_t        s1_wr_r;
  logic [7:0] s1_wdata_r;
  logic [7:0] s1_p0_r;
  logic [7:0] s1_p1_r;

  logic       out_valid_r;
  logic [7:0] rd_r, rd_nxt;
  logic       snd1_r, snd2_r;
  logic [7:0] snd_byte_r;
  logic       flip_r;
  logic [2:0] prio_r;
  logic [7:0] scrx_r, scry_r;
  logic       snd1_nxt, snd2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  // Hold the transaction next to the registered memory read data
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src_r   <= src;
      s1_wr_r    <= wr;
      s1_wdata_r <= write_data;
      s1_p0_r    <= player_port_0;
      s1_p1_r    <= player_port_1;
    end
  end

  always_comb begin
    case (s1_src_r)
      SRC_ROM:  rd_nxt = q.rom;
      SRC_BGC:  rd_nxt = q.bgc;
      SRC_BGV:  rd_nxt = q.bgv;
      SRC_FGC:  rd_nxt = q.fgc;
      SRC_FGV:  rd_nxt = q.fgv;
      SRC_SPR:  rd_nxt = q.spr;
      SRC_WRAM: rd_nxt = q.wram;
      SRC_P0:   rd_nxt = s1_p0_r;
      SRC_P1:   rd_nxt = s1_p1_r;
      SRC_DIP1: rd_nxt = dip1;
      SRC_DIP2: rd_nxt = dip2;
      default:  rd_nxt = BYTE_FF;
    endcase
  end

  assign snd1_nxt = s1_valid_r && (s1_wr_r == WR_SND1);
  assign snd2_nxt = s1_valid_r && (s1_wr_r == WR_SND2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      snd1_r      <= 1'b0;
      snd2_r      <= 1'b0;
      flip_r      <= 1'b0;
      prio_r      <= '0;
      scrx_r      <= '0;
      scry_r      <= '0;
    end else begin
      out_valid_r <= s1_valid_r;
      snd1_r      <= snd1_nxt;
      snd2_r      <= snd2_nxt;
      if (s1_valid_r) begin
        case (s1_wr_r)
          WR_LATCH: begin
            flip_r <= s1_wdata_r[0];
            prio_r <= s1_wdata_r[3:1];
          end
          WR_SCRX: scrx_r <= s1_wdata_r;
          WR_SCRY: scry_r <= s1_wdata_r;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_r       <= rd_nxt;
    snd_byte_r <= (snd1_nxt || snd2_nxt) ? s1_wdata_r : '0;
  end

  assign valid           = out_valid_r;
  assign read_data       = rd_r;
  assign sound_strobe_1  = snd1_r;
  assign sound_strobe_2  = snd2_r;
  assign sound_byte      = snd_byte_r;
  assign flip_screen     = flip_r;
  assign priority_select = prio_r;
  assign scroll_x        = scrx_r;
  assign scroll_y        = scry_r;

endmodule

>>> rtl/core/arcade_board_memory_map_core.sv
// Top level of the arcade main board bus decoder.
//
//   port group  direction  transfer
//   in_*        input      start && !busy accepts one bus transaction
//   out_*       output     out_valid marks a result for one cycle
//   cfg_*       input      cfg_we writes DIP bank cfg_index at once
//
// An accepted transaction passes the memory read register, then the result
// register, before its result shows on out_*; one transaction can enter
// every cycle while busy is low, so the rate is one per cycle.
// After reset busy stays high while every RAM is swept to zero (the work
// RAM depth sets the length of the sweep); program ROM keeps its data.
// The receiver cannot stall: each result is on out_* for exactly one cycle.
`timescale 1ns / 1ps
module arcade_board_memory_map_core
  import abmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [15:0] in_protection_pointer,
  input  logic [7:0]  in_player_port_0,
  input  logic [7:0]  in_player_port_1,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  output logic        out_sound_strobe_1,
  output logic        out_sound_strobe_2,
  output logic [7:0]  out_sound_byte,
  output logic        out_flip_screen,
  output logic [2:0]  out_priority_select,
  output logic [7:0]  out_scroll_x,
  output logic [7:0]  out_scroll_y
);

  logic       accept;
  logic       mem_busy;
  dec_t       dec;
  rdq_t       rdq;
  logic [7:0] dip1_r;
  logic [7:0] dip2_r;

  assign busy   = mem_busy;
  assign accept = start && !mem_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dip1_r <= BYTE_FF;
      dip2_r <= BYTE_FF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIP1: dip1_r <= cfg_wdata;
        CFG_DIP2: dip2_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  abmm_decode u_decode (
    .command            (in_command),
    .address            (in_address),
    .protection_pointer (in_protection_pointer),
    .dec                (dec)
  );

  abmm_mem u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .dec        (dec),
    .address    (in_address),
    .write_data (in_write_data),
    .q          (rdq),
    .busy       (mem_busy)
  );

  abmm_result u_result (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .src             (dec.src),
    .wr              (dec.wr),
    .write_data      (in_write_data),
    .player_port_0   (in_player_port_0),
    .player_port_1   (in_player_port_1),
    .dip1            (dip1_r),
    .dip2            (dip2_r),
    .q               (rdq),
    .valid           (out_valid),
    .read_data       (out_read_data),
    .sound_strobe_1  (out_sound_strobe_1),
    .sound_strobe_2  (out_sound_strobe_2),
    .sound_byte      (out_sound_byte),
    .flip_screen     (out_flip_screen),
    .priority_select (out_priority_select),
    .scroll_x        (out_scroll_x),
    .scroll_y        (out_scroll_y)
  );

endmodule

>>> rtl/core/abmm_checker.sv
// Port-level checker for the bus decoder, bound to the top level.
`timescale 1ns / 1ps
`include "arcade_board_memory_map_core_macros.svh"
module abmm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_sound_strobe_1,
  input logic        out_sound_strobe_2,
  input logic        out_flip_screen,
  input logic [2:0]  out_priority_select,
  input logic [7:0]  out_scroll_x,
  input logic [7:0]  out_scroll_y
);

  `ABMM_ASSERT_IMPL(a_result_follows, start && !busy, ##2 out_valid)
  `ABMM_ASSERT_IMPL(a_result_has_cause, out_valid, $past(start && !busy, 2))
  `ABMM_ASSERT_IMPL(a_strobe_on_result, out_sound_strobe_1 || out_sound_strobe_2, out_valid && !(out_sound_strobe_1 && out_sound_strobe_2))
  `ABMM_ASSERT_IMPL(a_latches_hold, !out_valid && $past(rst_n), $stable(out_flip_screen) && $stable(out_priority_select) && $stable(out_scroll_x) && $stable(out_scroll_y))
  `ABMM_ASSERT_NEXT(a_no_result_while_clearing, busy, !out_valid)

endmodule

bind arcade_board_memory_map_core abmm_checker u_abmm_checker (.*);
